// ----- rtl/psc_pkg.sv -----
// shared types, constants and crc helpers for the packet slot table
package psc_pkg;

    // table geometry and limits
    localparam int SLOTS   = 500;
    localparam int MAX_LEN = 4096;
    localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // fixed field widths
    localparam int SEQ_W      = 32;
    localparam int LEN_W      = 13;
    localparam int STATUS_W   = 3;
    localparam int SLOT_OUT_W = 9;
    localparam int COUNT_W    = 9;
    localparam int BYTES_W    = 21;
    localparam int MEM_W      = 1 + SEQ_W + LEN_W;

    // slot index comes from bits 31:12 of the mixed crc
    localparam int MIX_LSB = 12;
    localparam int MIX_W   = 32 - MIX_LSB;

    // reciprocal for the modulo: exact for any 20-bit value while SLOTS <= 4096
    localparam int          RECIP_SH = 32;
    localparam int          RECIP_W  = 33;
    localparam logic [63:0] RECIP    = ((64'd1 << RECIP_SH) + 64'(SLOTS) - 64'd1) / 64'(SLOTS);
    localparam int          PROD_W   = MIX_W + RECIP_W;

    // crc polynomials and seed
    localparam logic [31:0] POLY_STD    = 32'hEDB8_8320;
    localparam logic [31:0] POLY_CUSTOM = 32'h04C1_1DB7;
    localparam logic [31:0] CRC_SEED    = 32'hFFFF_FFFF;

    // configuration port
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;
    localparam int KEY_BYTES  = 20;
    localparam int KEY_CNT_W  = $clog2(KEY_BYTES + 1);

    localparam logic [2:0] REG_SRC_ADDR = 3'd0;
    localparam logic [2:0] REG_DST_ADDR = 3'd1;
    localparam logic [2:0] REG_SRC_PORT = 3'd2;
    localparam logic [2:0] REG_DST_PORT = 3'd3;
    localparam logic [2:0] REG_SRC_QP   = 3'd4;
    localparam logic [2:0] REG_DST_QP   = 3'd5;

    localparam logic [15:0] DST_PORT_RESET = 16'd4791;

    // request kinds
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    // result codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_STORED    = 3'd0,
        STAT_REPLACED  = 3'd1,
        STAT_COLLISION = 3'd2,
        STAT_BAD_LEN   = 3'd3,
        STAT_HIT       = 3'd4,
        STAT_EMPTY     = 3'd5,
        STAT_OTHER_SEQ = 3'd6
    } status_t;

    // table controller states
    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_RESOLVE
    } ctrl_state_t;

    // signature unit status towards the controller
    typedef struct packed {
        logic        busy;
        logic [31:0] signature;
    } sig_status_t;

    // slot hash result towards the controller
    typedef struct packed {
        logic             done;
        logic [IDX_W-1:0] idx;
    } hash_res_t;

    // one byte through the reflected crc loop
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                             input logic [7:0]  data,
                                             input logic [31:0] poly);
        logic [31:0] c;
        c = crc_in ^ {24'd0, data};
        for (int b = 0; b < 8; b++) begin
            c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ----- rtl/packet_slot_cache_crc_index.sv -----
// packet slot table top level: slot memory controller, totals and result register
// a result leaves through the result register after the hash stages and the slot memory read;
//   the resolve state waits while the previous result is still held
// requests: one at a time; a new request is taken only after the previous one has passed the
//   hash pipeline and the slot memory read and write-back
// reset: a clearing pass writes all SLOTS entries, one per cycle, and the flow signature is
//   computed (also after any register write); no request is taken until both are done
module packet_slot_cache_crc_index import psc_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // request channel
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_req_type,
    input  logic [SEQ_W-1:0]      s_seq_num,
    input  logic [LEN_W-1:0]      s_pkt_length,
    // result channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [STATUS_W-1:0]   m_status,
    output logic [SLOT_OUT_W-1:0] m_slot_index,
    output logic [LEN_W-1:0]      m_found_length,
    output logic [COUNT_W-1:0]    m_entry_count,
    output logic [BYTES_W-1:0]    m_byte_total,
    output logic [SEQ_W-1:0]      m_lowest_seq,
    output logic [SEQ_W-1:0]      m_highest_seq,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    ctrl_state_t state_reg, state_next;

    sig_status_t sig_st;
    hash_res_t   hash_res;

    logic             hash_start;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [MEM_W-1:0] ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    logic [MEM_W-1:0] ram_rdata;

    logic [IDX_W-1:0] clr_reg, clr_next;
    logic [IDX_W-1:0] idx_reg;
    logic             req_reg;
    logic [SEQ_W-1:0] seq_reg;
    logic [LEN_W-1:0] len_reg;

    logic [COUNT_W-1:0] count_reg, count_next;
    logic [BYTES_W-1:0] bytes_reg, bytes_next;
    logic [SEQ_W-1:0]   min_reg, min_next;
    logic [SEQ_W-1:0]   max_reg, max_next;

    logic                m_valid_reg, m_valid_next;
    status_t             status_reg;
    logic [IDX_W-1:0]    slot_reg;
    logic [LEN_W-1:0]    found_reg;

    logic                load_out;
    logic                out_free;

    // decoded slot entry and decision
    logic             ent_valid;
    logic [SEQ_W-1:0] ent_seq;
    logic [LEN_W-1:0] ent_len;
    logic             bad_len;
    logic             seq_match;
    status_t          status_calc;
    logic             do_write;
    logic [LEN_W-1:0] found_calc;

    psc_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .sig_st  (sig_st)
    );

    psc_hash u_hash (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (hash_start),
        .seq_num   (s_seq_num),
        .signature (sig_st.signature),
        .hash_res  (hash_res)
    );

    psc_ram #(
        .WIDTH (MEM_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // slot entry fields
    assign {ent_valid, ent_seq, ent_len} = ram_rdata;
    assign bad_len   = (len_reg == '0) || (32'(len_reg) > 32'(MAX_LEN));
    assign seq_match = (ent_seq == seq_reg);

    // insert or lookup outcome
    always_comb begin
        do_write   = 1'b0;
        found_calc = '0;
        if (req_reg == REQ_INSERT) begin
            if (bad_len) begin
                status_calc = STAT_BAD_LEN;
            end else if (ent_valid && !seq_match) begin
                status_calc = STAT_COLLISION;
            end else begin
                do_write    = 1'b1;
                status_calc = ent_valid ? STAT_REPLACED : STAT_STORED;
            end
        end else begin
            if (!ent_valid) begin
                status_calc = STAT_EMPTY;
            end else if (!seq_match) begin
                status_calc = STAT_OTHER_SEQ;
            end else begin
                status_calc = STAT_HIT;
                found_calc  = ent_len;
            end
        end
    end

    assign out_free = !m_valid_reg || m_ready;

    // controller next state, memory access and totals
    always_comb begin
        state_next = state_reg;
        clr_next   = clr_reg;
        s_ready    = 1'b0;
        hash_start = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = idx_reg;
        ram_wdata  = {1'b1, seq_reg, len_reg};
        ram_raddr  = idx_reg;
        load_out   = 1'b0;
        count_next = count_reg;
        bytes_next = bytes_reg;
        min_next   = min_reg;
        max_next   = max_reg;
        unique case (state_reg)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                if (clr_reg == IDX_W'(SLOTS - 1)) begin
                    state_next = S_IDLE;
                end else begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            S_IDLE: begin
                s_ready = !sig_st.busy;
                if (s_valid && !sig_st.busy) begin
                    hash_start = 1'b1;
                    state_next = S_HASH;
                end
            end
            S_HASH: begin
                ram_raddr = hash_res.idx;
                if (hash_res.done) begin
                    state_next = S_RESOLVE;
                end
            end
            S_RESOLVE: begin
                if (out_free) begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                    if (do_write) begin
                        ram_we = 1'b1;
                        if (ent_valid) begin
                            bytes_next = bytes_reg - BYTES_W'(ent_len) + BYTES_W'(len_reg);
                        end else begin
                            count_next = count_reg + 1'b1;
                            bytes_next = bytes_reg + BYTES_W'(len_reg);
                        end
                        if (seq_reg < min_reg) begin
                            min_next = seq_reg;
                        end
                        if (seq_reg > max_reg) begin
                            max_next = seq_reg;
                        end
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control state and totals
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            count_reg <= '0;
            bytes_reg <= '0;
            min_reg   <= '1;
            max_reg   <= '0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            count_reg <= count_next;
            bytes_reg <= bytes_next;
            min_reg   <= min_next;
            max_reg   <= max_next;
        end
    end

    // request fields and slot index
    always_ff @(posedge aclk) begin
        if (hash_start) begin
            req_reg <= s_req_type;
            seq_reg <= s_seq_num;
            len_reg <= s_pkt_length;
        end
        if (state_reg == S_HASH && hash_res.done) begin
            idx_reg <= hash_res.idx;
        end
    end

    // result register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            status_reg <= status_calc;
            slot_reg   <= idx_reg;
            found_reg  <= found_calc;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = status_reg;
    assign m_slot_index   = SLOT_OUT_W'(slot_reg);
    assign m_found_length = found_reg;
    assign m_entry_count  = count_reg;
    assign m_byte_total   = bytes_reg;
    assign m_lowest_seq   = min_reg;
    assign m_highest_seq  = max_reg;

endmodule

// ----- rtl/psc_ram.sv -----
// generic single-port-write, single-port-read ram with registered read data
module psc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/psc_cfg.sv -----
// connection registers and the byte-serial flow signature unit
module psc_cfg import psc_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output sig_status_t           sig_st
);

    logic [31:0]          src_addr_reg;
    logic [31:0]          dst_addr_reg;
    logic [15:0]          sport_reg;
    logic [15:0]          dport_reg;
    logic [31:0]          src_qp_reg;
    logic [31:0]          dst_qp_reg;
    logic [31:0]          crc_reg;
    logic [31:0]          crc_next;
    logic [31:0]          sig_reg;
    logic                 busy_reg;
    logic [KEY_CNT_W-1:0] cnt_reg;
    logic [2:0]           reg_sel;
    logic                 wr_en;
    logic [8*KEY_BYTES-1:0] key_vec;
    logic [7:0]           key_byte;

    assign pready  = 1'b1;
    assign reg_sel = paddr[4:2];
    assign wr_en   = psel && penable && pwrite && pready;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_addr_reg <= '0;
            dst_addr_reg <= '0;
            sport_reg    <= '0;
            dport_reg    <= DST_PORT_RESET;
            src_qp_reg   <= '0;
            dst_qp_reg   <= '0;
        end else if (wr_en) begin
            unique case (reg_sel)
                REG_SRC_ADDR: src_addr_reg <= pwdata;
                REG_DST_ADDR: dst_addr_reg <= pwdata;
                REG_SRC_PORT: sport_reg    <= pwdata[15:0];
                REG_DST_PORT: dport_reg    <= pwdata[15:0];
                REG_SRC_QP:   src_qp_reg   <= pwdata;
                REG_DST_QP:   dst_qp_reg   <= pwdata;
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        unique case (reg_sel)
            REG_SRC_ADDR: prdata = src_addr_reg;
            REG_DST_ADDR: prdata = dst_addr_reg;
            REG_SRC_PORT: prdata = {16'd0, sport_reg};
            REG_DST_PORT: prdata = {16'd0, dport_reg};
            REG_SRC_QP:   prdata = src_qp_reg;
            REG_DST_QP:   prdata = dst_qp_reg;
            default:      prdata = '0;
        endcase
    end

    // key bytes in feed order, byte i at bits 8i+7:8i
    // addresses go in network order, the rest least significant byte first
    assign key_vec = {dst_qp_reg, src_qp_reg, dport_reg, sport_reg,
                      dst_addr_reg[7:0], dst_addr_reg[15:8],
                      dst_addr_reg[23:16], dst_addr_reg[31:24],
                      src_addr_reg[7:0], src_addr_reg[15:8],
                      src_addr_reg[23:16], src_addr_reg[31:24]};

    assign key_byte = key_vec[8*cnt_reg +: 8];
    assign crc_next = crc_byte(crc_reg, key_byte, POLY_CUSTOM);

    // one key byte per cycle; any write restarts the pass
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
            crc_reg  <= CRC_SEED;
        end else if (wr_en) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
            crc_reg  <= CRC_SEED;
        end else if (busy_reg) begin
            crc_reg <= crc_next;
            if (cnt_reg == KEY_CNT_W'(KEY_BYTES - 1)) begin
                busy_reg <= 1'b0;
            end else begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // finished signature
    always_ff @(posedge aclk) begin
        if (busy_reg && !wr_en && cnt_reg == KEY_CNT_W'(KEY_BYTES - 1)) begin
            sig_reg <= ~crc_next;
        end
    end

    assign sig_st.busy      = busy_reg;
    assign sig_st.signature = sig_reg;

endmodule

// ----- rtl/psc_hash.sv -----
// slot index pipeline: dual crc over signature and sequence, then modulo SLOTS
module psc_hash import psc_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [SEQ_W-1:0] seq_num,
    input  logic [31:0]      signature,
    output hash_res_t        hash_res
);

    logic [63:0]        hash_buf;
    logic [31:0]        crc_std;
    logic [31:0]        crc_cus;
    logic [31:0]        mix;
    logic [MIX_W-1:0]   mix_reg;
    logic [MIX_W-1:0]   x_reg;
    logic [MIX_W-1:0]   q_reg;
    logic [PROD_W-1:0]  prod;
    logic [MIX_W-1:0]   qm;
    logic               v1_reg;
    logic               v2_reg;

    // both crcs over the eight bytes, signature first
    assign hash_buf = {seq_num, signature};

    always_comb begin
        crc_std = CRC_SEED;
        crc_cus = CRC_SEED;
        for (int i = 0; i < 8; i++) begin
            crc_std = crc_byte(crc_std, hash_buf[8*i +: 8], POLY_STD);
            crc_cus = crc_byte(crc_cus, hash_buf[8*i +: 8], POLY_CUSTOM);
        end
        mix = (~crc_std) ^ (~crc_cus);
    end

    // quotient by reciprocal multiply
    assign prod = PROD_W'(mix_reg) * PROD_W'(RECIP[RECIP_W-1:0]);

    // remainder from the registered quotient
    assign qm = MIX_W'(q_reg * MIX_W'(SLOTS));

    always_ff @(posedge aclk) begin
        if (start) begin
            mix_reg <= mix[31:MIX_LSB];
        end
        if (v1_reg) begin
            x_reg <= mix_reg;
            q_reg <= prod[RECIP_SH +: MIX_W];
        end
    end

    // stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= start;
            v2_reg <= v1_reg;
        end
    end

    assign hash_res.done = v2_reg;
    assign hash_res.idx  = IDX_W'(x_reg - qm);

endmodule

// ----- tb/psc_result_checker.sv -----
// result checker: tracks the slot table and totals, compares every result with its prediction
module psc_result_checker import psc_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // request channel
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic                  s_req_type,
    input  logic [SEQ_W-1:0]      s_seq_num,
    input  logic [LEN_W-1:0]      s_pkt_length,
    // result channel
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic [STATUS_W-1:0]   m_status,
    input  logic [SLOT_OUT_W-1:0] m_slot_index,
    input  logic [LEN_W-1:0]      m_found_length,
    input  logic [COUNT_W-1:0]    m_entry_count,
    input  logic [BYTES_W-1:0]    m_byte_total,
    input  logic [SEQ_W-1:0]      m_lowest_seq,
    input  logic [SEQ_W-1:0]      m_highest_seq,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    input  logic [CFG_DATA_W-1:0] prdata,
    input  logic                  pready,
    // to the testbench top
    output int                    fail_count,
    output int                    backlog
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int INDEX_BYTES  = 8;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        status_t               status;
        logic [SLOT_OUT_W-1:0] slot_index;
        logic [LEN_W-1:0]      found_length;
        logic [COUNT_W-1:0]    entry_count;
        logic [BYTES_W-1:0]    byte_total;
        logic [SEQ_W-1:0]      lowest_seq;
        logic [SEQ_W-1:0]      highest_seq;
    } slot_result_t;

    // connection registers and the signature derived from them
    logic [31:0]        conn_cfg [6];
    logic [31:0]        flow_sig;

    // shadow slot table and running totals
    logic               slot_used [SLOTS];
    logic [SEQ_W-1:0]   slot_psn  [SLOTS];
    logic [LEN_W-1:0]   slot_len  [SLOTS];
    logic [COUNT_W-1:0] entries;
    logic [BYTES_W-1:0] bytes_held;
    logic [SEQ_W-1:0]   psn_low;
    logic [SEQ_W-1:0]   psn_high;

    slot_result_t       expected_results [$];
    int                 mismatches = 0;

    initial begin
        fail_count = 0;
        backlog    = 0;
    end

    // reflected crc, byte 0 in the low bits of the stream
    function automatic logic [31:0] crc_reflected(input logic [159:0] stream,
                                                  input int nbytes,
                                                  input logic [31:0] poly);
        logic [31:0] c;
        c = 32'hFFFF_FFFF;
        for (int i = 0; i < nbytes; i++) begin
            c ^= {24'd0, stream[8*i +: 8]};
            for (int b = 0; b < 8; b++) begin
                c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
            end
        end
        return ~c;
    endfunction

    // ip addresses go in most significant octet first
    function automatic logic [31:0] net_order(input logic [31:0] w);
        return {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

    function automatic logic [31:0] connection_signature();
        return crc_reflected({conn_cfg[REG_DST_QP], conn_cfg[REG_SRC_QP],
                              conn_cfg[REG_DST_PORT][15:0], conn_cfg[REG_SRC_PORT][15:0],
                              net_order(conn_cfg[REG_DST_ADDR]),
                              net_order(conn_cfg[REG_SRC_ADDR])},
                             KEY_BYTES, POLY_CUSTOM);
    endfunction

    // slot = (std crc xor custom crc of signature+psn) bits 31:12, modulo table size
    function automatic logic [SLOT_OUT_W-1:0] slot_for(input logic [SEQ_W-1:0] psn);
        logic [159:0] stream;
        logic [31:0]  mix;
        stream = {96'd0, psn, flow_sig};
        mix = crc_reflected(stream, INDEX_BYTES, POLY_STD)
            ^ crc_reflected(stream, INDEX_BYTES, POLY_CUSTOM);
        return SLOT_OUT_W'(mix[31:12] % SLOTS);
    endfunction

    // apply one request to the shadow table and give the result it should produce
    function automatic slot_result_t apply_request(input logic req,
                                                   input logic [SEQ_W-1:0] psn,
                                                   input logic [LEN_W-1:0] len);
        slot_result_t          r;
        logic [SLOT_OUT_W-1:0] idx;
        idx            = slot_for(psn);
        r.found_length = '0;
        if (req == REQ_INSERT) begin
            if (len == 0 || len > MAX_LEN) begin
                r.status = STAT_BAD_LEN;
            end else if (slot_used[idx] && slot_psn[idx] != psn) begin
                r.status = STAT_COLLISION;
            end else begin
                if (slot_used[idx]) begin
                    bytes_held = bytes_held - BYTES_W'(slot_len[idx]);
                    r.status   = STAT_REPLACED;
                end else begin
                    entries  = entries + 1'b1;
                    r.status = STAT_STORED;
                end
                bytes_held     = bytes_held + BYTES_W'(len);
                slot_used[idx] = 1'b1;
                slot_psn[idx]  = psn;
                slot_len[idx]  = len;
                if (psn < psn_low) psn_low = psn;
                if (psn > psn_high) psn_high = psn;
            end
        end else begin
            if (!slot_used[idx]) begin
                r.status = STAT_EMPTY;
            end else if (slot_psn[idx] != psn) begin
                r.status = STAT_OTHER_SEQ;
            end else begin
                r.status       = STAT_HIT;
                r.found_length = slot_len[idx];
            end
        end
        r.slot_index  = idx;
        r.entry_count = entries;
        r.byte_total  = bytes_held;
        r.lowest_seq  = psn_low;
        r.highest_seq = psn_high;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("mismatch on %s: expected %0h, got %0h", name, want, got);
        end
    endfunction

    always @(posedge aclk) begin
        slot_result_t want;
        logic [2:0]   reg_sel;
        if (!aresetn) begin
            // reset values of registers, table and totals
            foreach (conn_cfg[i]) conn_cfg[i] = '0;
            conn_cfg[REG_DST_PORT] = {16'd0, DST_PORT_RESET};
            flow_sig = connection_signature();
            foreach (slot_used[i]) begin
                slot_used[i] = 1'b0;
                slot_psn[i]  = '0;
                slot_len[i]  = '0;
            end
            entries    = '0;
            bytes_held = '0;
            psn_low    = '1;
            psn_high   = '0;
            expected_results.delete();
        end else begin
            // register writes take effect at once, reads must return the held value
            if (psel && penable && pready) begin
                reg_sel = paddr[CFG_ADDR_W-1:2];
                if (reg_sel <= REG_DST_QP) begin
                    if (pwrite) begin
                        if (reg_sel == REG_SRC_PORT || reg_sel == REG_DST_PORT)
                            conn_cfg[reg_sel] = {16'd0, pwdata[15:0]};
                        else
                            conn_cfg[reg_sel] = pwdata;
                        flow_sig = connection_signature();
                    end else begin
                        check_field("register readback", conn_cfg[reg_sel], prdata);
                    end
                end
            end
            // result channel against the oldest prediction
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("unexpected result: status %0d slot %0d",
                                 m_status, m_slot_index);
                end else begin
                    want = expected_results.pop_front();
                    check_field("status", want.status, m_status);
                    check_field("slot_index", want.slot_index, m_slot_index);
                    check_field("found_length", want.found_length, m_found_length);
                    check_field("entry_count", want.entry_count, m_entry_count);
                    check_field("byte_total", want.byte_total, m_byte_total);
                    check_field("lowest_seq", want.lowest_seq, m_lowest_seq);
                    check_field("highest_seq", want.highest_seq, m_highest_seq);
                end
            end
            // each accepted request predicts one result
            if (s_valid && s_ready)
                expected_results.push_back(apply_request(s_req_type, s_seq_num, s_pkt_length));
        end
        backlog    <= expected_results.size();
        fail_count <= mismatches;
    end

endmodule

// ----- tb/tb_packet_slot_cache_crc_index.sv -----
// testbench top: clock, reset, request and register stimulus, final verdict
module tb_packet_slot_cache_crc_index import psc_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         IDLE_PCT       = 20;
    localparam int         RAND_PER_PHASE = 133;
    localparam int         POOL_DEPTH     = 48;
    localparam int         DRAIN_CYCLES   = 6;
    localparam int         STALL_LIMIT    = 6000;
    localparam int         LEN_ALL        = (1 << LEN_W) - 1;
    localparam logic [2:0] REG_SPARE_LO   = 3'd6;
    localparam logic [2:0] REG_SPARE_HI   = 3'd7;

    logic                  aclk         = 1'b0;
    logic                  aresetn      = 1'b0;
    logic                  s_valid      = 1'b0;
    logic                  s_req_type   = REQ_INSERT;
    logic [SEQ_W-1:0]      s_seq_num    = '0;
    logic [LEN_W-1:0]      s_pkt_length = '0;
    logic                  m_ready      = 1'b0;
    logic                  psel         = 1'b0;
    logic                  penable      = 1'b0;
    logic                  pwrite       = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr        = '0;
    logic [CFG_DATA_W-1:0] pwdata       = '0;

    logic                  s_ready;
    logic                  m_valid;
    logic [STATUS_W-1:0]   m_status;
    logic [SLOT_OUT_W-1:0] m_slot_index;
    logic [LEN_W-1:0]      m_found_length;
    logic [COUNT_W-1:0]    m_entry_count;
    logic [BYTES_W-1:0]    m_byte_total;
    logic [SEQ_W-1:0]      m_lowest_seq;
    logic [SEQ_W-1:0]      m_highest_seq;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    int                    fail_count;
    int                    backlog;
    int                    quiet_cycles = 0;
    bit                    steady       = 1'b0;
    logic [SEQ_W-1:0]      recent_psn [$];

    always #10 aclk = ~aclk;

    packet_slot_cache_crc_index DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_seq_num      (s_seq_num),
        .s_pkt_length   (s_pkt_length),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_slot_index   (m_slot_index),
        .m_found_length (m_found_length),
        .m_entry_count  (m_entry_count),
        .m_byte_total   (m_byte_total),
        .m_lowest_seq   (m_lowest_seq),
        .m_highest_seq  (m_highest_seq),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    psc_result_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_seq_num      (s_seq_num),
        .s_pkt_length   (s_pkt_length),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_slot_index   (m_slot_index),
        .m_found_length (m_found_length),
        .m_entry_count  (m_entry_count),
        .m_byte_total   (m_byte_total),
        .m_lowest_seq   (m_lowest_seq),
        .m_highest_seq  (m_highest_seq),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .fail_count     (fail_count),
        .backlog        (backlog)
    );

    // result side back-pressure
    always @(posedge aclk) begin
        m_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // watchdog on cycles with no request or result moving
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // one request, with random idle cycles ahead of it unless steady is set
    task automatic send_request(input logic req, input logic [SEQ_W-1:0] psn,
                                input logic [LEN_W-1:0] len);
        if (!steady) begin
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid      <= 1'b1;
        s_req_type   <= req;
        s_seq_num    <= psn;
        s_pkt_length <= len;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // setup then access phase on the register port
    task automatic register_access(input logic write, input logic [2:0] sel,
                                   input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // stop requests and wait for every predicted result to drain
    task automatic settle_table();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (backlog != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // new connection: all six registers, the unused slots, then readback
    task automatic program_connection(input logic [31:0] src_ip, input logic [31:0] dst_ip,
                                      input logic [31:0] sport, input logic [31:0] dport,
                                      input logic [31:0] src_qp, input logic [31:0] dst_qp);
        register_access(1'b1, REG_SRC_ADDR, src_ip);
        register_access(1'b1, REG_DST_ADDR, dst_ip);
        register_access(1'b1, REG_SRC_PORT, sport);
        register_access(1'b1, REG_DST_PORT, dport);
        register_access(1'b1, REG_SRC_QP, src_qp);
        register_access(1'b1, REG_DST_QP, dst_qp);
        register_access(1'b1, REG_SPARE_LO, $urandom);
        register_access(1'b1, REG_SPARE_HI, $urandom);
        register_access(1'b0, REG_SRC_ADDR, '0);
        register_access(1'b0, REG_DST_ADDR, '0);
        register_access(1'b0, REG_SRC_PORT, '0);
        register_access(1'b0, REG_DST_PORT, '0);
        register_access(1'b0, REG_SRC_QP, '0);
        register_access(1'b0, REG_DST_QP, '0);
    endtask

    // inserts and lookups on recently used psns (45 in 100 picks), the rest fresh or corner values
    task automatic random_traffic(input int n);
        logic             req;
        logic [SEQ_W-1:0] psn;
        logic [LEN_W-1:0] len;
        int               pick;
        for (int k = 0; k < n; k++) begin
            req  = ($urandom_range(0, 99) < 55) ? REQ_INSERT : REQ_LOOKUP;
            pick = $urandom_range(0, 99);
            if (recent_psn.size() != 0 && pick < 45)
                psn = recent_psn[$urandom_range(0, recent_psn.size() - 1)];
            else if (pick < 50)
                psn = '0;
            else if (pick < 55)
                psn = '1;
            else
                psn = $urandom;
            pick = $urandom_range(0, 99);
            if (req == REQ_LOOKUP)
                len = LEN_W'($urandom_range(0, LEN_ALL));
            else if (pick < 5)
                len = '0;
            else if (pick < 11)
                len = LEN_W'($urandom_range(MAX_LEN + 1, LEN_ALL));
            else if (pick < 16)
                len = LEN_W'(MAX_LEN);
            else
                len = LEN_W'($urandom_range(1, MAX_LEN));
            if (req == REQ_INSERT) begin
                recent_psn.push_back(psn);
                if (recent_psn.size() > POOL_DEPTH) void'(recent_psn.pop_front());
            end
            send_request(req, psn, len);
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // corner requests on the reset connection
        send_request(REQ_LOOKUP, 32'h0000_0000, LEN_W'(LEN_ALL));
        send_request(REQ_INSERT, 32'h0000_0000, '0);
        send_request(REQ_INSERT, 32'h0000_0000, LEN_W'(MAX_LEN + 1));
        send_request(REQ_INSERT, 32'hFFFF_FFFF, LEN_W'(LEN_ALL));
        send_request(REQ_INSERT, 32'h0000_0000, LEN_W'(1));
        send_request(REQ_LOOKUP, 32'h0000_0000, '0);
        send_request(REQ_INSERT, 32'h0000_0000, LEN_W'(MAX_LEN));
        send_request(REQ_LOOKUP, 32'h0000_0000, '0);
        send_request(REQ_INSERT, 32'hFFFF_FFFF, LEN_W'(MAX_LEN));
        send_request(REQ_LOOKUP, 32'hFFFF_FFFF, '0);
        send_request(REQ_INSERT, 32'hFFFF_FFFF, LEN_W'(1));
        send_request(REQ_INSERT, 32'h5555_5555, 13'h0AAA);
        send_request(REQ_INSERT, 32'hAAAA_AAAA, 13'h1555);
        send_request(REQ_INSERT, 32'hAAAA_AAAA, 13'h0555);
        send_request(REQ_LOOKUP, 32'h5555_5555, 13'h1555);
        send_request(REQ_LOOKUP, 32'hAAAA_AAAA, 13'h0AAA);
        send_request(REQ_LOOKUP, 32'h1234_5678, '0);
        send_request(REQ_LOOKUP, 32'hFFFF_FFFF, '0);
        settle_table();

        // all ones, port values carry bits above their width
        program_connection('1, '1, '1, '1, '1, '1);
        random_traffic(RAND_PER_PHASE);
        settle_table();

        // all zeros, both sides without idle cycles
        steady = 1'b1;
        program_connection('0, '0, '0, '0, '0, '0);
        random_traffic(RAND_PER_PHASE);
        settle_table();
        steady = 1'b0;

        // random connections
        program_connection($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        random_traffic(RAND_PER_PHASE);
        settle_table();
        program_connection($urandom, $urandom, $urandom, {16'd0, DST_PORT_RESET},
                           $urandom, $urandom);
        random_traffic(RAND_PER_PHASE);
        settle_table();

        if (fail_count == 0 && backlog == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
